### src/diff_drive_pose_integrator_unit_macros.svh
// Assertion macros for the pose integrator
`ifndef DIFF_DRIVE_POSE_INTEGRATOR_UNIT_MACROS_SVH
`define DIFF_DRIVE_POSE_INTEGRATOR_UNIT_MACROS_SVH

// same-cycle implication
`define DPI_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pose integrator assertion failed");

// next-cycle implication
`define DPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pose integrator assertion failed");

`endif

### src/dpi_pkg.sv
// Shared types, constants and tables of the pose integrator
package dpi_pkg;

    localparam int MAX_STEPS_DEF = 64;
    localparam int APB_AW        = 4;

    localparam logic [15:0] RADIUS_RST = 16'd3277;
    localparam logic [19:0] SEP_RST    = 20'd32768;
    localparam logic [19:0] STEP_RST   = 20'd1000;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SEP    = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;

    localparam logic [31:0] TWO_MEG      = 32'd2000000;
    localparam logic [31:0] ONE_MEG      = 32'd1000000;
    localparam logic [31:0] TURN_PER_RAD = 32'd683565276;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [4:0]         TRIG_LAST   = 5'd29;
    localparam logic [4:0]         MUL_LAST    = 5'd31;
    localparam logic [6:0]         DIV_LAST    = 7'd95;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_DIVN,
        OP_CLIP,
        OP_DEND,
        OP_RSM,
        OP_RSMDT,
        OP_DIVD,
        OP_SEPN,
        OP_M1E6,
        OP_RTM,
        OP_RTMDT,
        OP_TURN,
        OP_DIVH,
        OP_TRIG,
        OP_MULX,
        OP_UPDX,
        OP_MULY,
        OP_UPDY
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIVN,
        S_CLIP,
        S_DEND,
        S_RSM,
        S_RSMDT,
        S_DIVD,
        S_SEPN,
        S_M1E6,
        S_RTM,
        S_RTMDT,
        S_TURN,
        S_DIVH,
        S_TRIG,
        S_MULX,
        S_UPDX,
        S_MULY,
        S_UPDY,
        S_PUB
    } t_state;

    typedef struct packed {
        logic go;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic quo_zero;
        logic last_step;
    } t_dp_sts;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### src/dpi_ctrl.sv
// Sequencer state machine of the pose integrator
`include "diff_drive_pose_integrator_unit_macros.svh"

module dpi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_cmd,
    input  logic             i_out_free,
    input  dpi_pkg::t_dp_sts i_dp_sts,
    output logic             o_in_stall,
    output logic             o_publish,
    output dpi_pkg::t_dp_cmd o_dp_cmd
);

    dpi_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dpi_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_cmd == dpi_pkg::CMD_ADVANCE) ? dpi_pkg::S_DIVN : dpi_pkg::S_PUB;
                end
            end
            dpi_pkg::S_DIVN:  if (i_dp_sts.done) n_state = dpi_pkg::S_CLIP;
            dpi_pkg::S_CLIP: begin
                if (i_dp_sts.done) begin
                    n_state = i_dp_sts.quo_zero ? dpi_pkg::S_PUB : dpi_pkg::S_DEND;
                end
            end
            dpi_pkg::S_DEND:  if (i_dp_sts.done) n_state = dpi_pkg::S_RSM;
            dpi_pkg::S_RSM:   if (i_dp_sts.done) n_state = dpi_pkg::S_RSMDT;
            dpi_pkg::S_RSMDT: if (i_dp_sts.done) n_state = dpi_pkg::S_DIVD;
            dpi_pkg::S_DIVD:  if (i_dp_sts.done) n_state = dpi_pkg::S_SEPN;
            dpi_pkg::S_SEPN:  if (i_dp_sts.done) n_state = dpi_pkg::S_M1E6;
            dpi_pkg::S_M1E6:  if (i_dp_sts.done) n_state = dpi_pkg::S_RTM;
            dpi_pkg::S_RTM:   if (i_dp_sts.done) n_state = dpi_pkg::S_RTMDT;
            dpi_pkg::S_RTMDT: if (i_dp_sts.done) n_state = dpi_pkg::S_TURN;
            dpi_pkg::S_TURN:  if (i_dp_sts.done) n_state = dpi_pkg::S_DIVH;
            dpi_pkg::S_DIVH:  if (i_dp_sts.done) n_state = dpi_pkg::S_TRIG;
            dpi_pkg::S_TRIG:  if (i_dp_sts.done) n_state = dpi_pkg::S_MULX;
            dpi_pkg::S_MULX:  if (i_dp_sts.done) n_state = dpi_pkg::S_UPDX;
            dpi_pkg::S_UPDX:  if (i_dp_sts.done) n_state = dpi_pkg::S_MULY;
            dpi_pkg::S_MULY:  if (i_dp_sts.done) n_state = dpi_pkg::S_UPDY;
            dpi_pkg::S_UPDY: begin
                if (i_dp_sts.done) begin
                    n_state = i_dp_sts.last_step ? dpi_pkg::S_PUB : dpi_pkg::S_TRIG;
                end
            end
            dpi_pkg::S_PUB:   if (i_out_free) n_state = dpi_pkg::S_IDLE;
            default:          n_state = dpi_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_dp_cmd.go = 1'b1;
        o_dp_cmd.op = dpi_pkg::OP_NONE;
        o_publish   = 1'b0;
        o_in_stall  = 1'b1;
        case (r_state)
            dpi_pkg::S_IDLE: begin
                o_in_stall  = 1'b0;
                o_dp_cmd.go = i_in_valid;
                o_dp_cmd.op = dpi_pkg::OP_CAPTURE;
            end
            dpi_pkg::S_DIVN:  o_dp_cmd.op = dpi_pkg::OP_DIVN;
            dpi_pkg::S_CLIP:  o_dp_cmd.op = dpi_pkg::OP_CLIP;
            dpi_pkg::S_DEND:  o_dp_cmd.op = dpi_pkg::OP_DEND;
            dpi_pkg::S_RSM:   o_dp_cmd.op = dpi_pkg::OP_RSM;
            dpi_pkg::S_RSMDT: o_dp_cmd.op = dpi_pkg::OP_RSMDT;
            dpi_pkg::S_DIVD:  o_dp_cmd.op = dpi_pkg::OP_DIVD;
            dpi_pkg::S_SEPN:  o_dp_cmd.op = dpi_pkg::OP_SEPN;
            dpi_pkg::S_M1E6:  o_dp_cmd.op = dpi_pkg::OP_M1E6;
            dpi_pkg::S_RTM:   o_dp_cmd.op = dpi_pkg::OP_RTM;
            dpi_pkg::S_RTMDT: o_dp_cmd.op = dpi_pkg::OP_RTMDT;
            dpi_pkg::S_TURN:  o_dp_cmd.op = dpi_pkg::OP_TURN;
            dpi_pkg::S_DIVH:  o_dp_cmd.op = dpi_pkg::OP_DIVH;
            dpi_pkg::S_TRIG:  o_dp_cmd.op = dpi_pkg::OP_TRIG;
            dpi_pkg::S_MULX:  o_dp_cmd.op = dpi_pkg::OP_MULX;
            dpi_pkg::S_UPDX:  o_dp_cmd.op = dpi_pkg::OP_UPDX;
            dpi_pkg::S_MULY:  o_dp_cmd.op = dpi_pkg::OP_MULY;
            dpi_pkg::S_UPDY:  o_dp_cmd.op = dpi_pkg::OP_UPDY;
            dpi_pkg::S_PUB: begin
                o_dp_cmd.go = 1'b0;
                o_publish   = i_out_free;
            end
            default: o_dp_cmd.go = 1'b0;
        endcase
    end

    `DPI_ASSERT_NEXT(a_pub_to_idle, i_clk, i_rst_n, o_publish, r_state == dpi_pkg::S_IDLE)

endmodule

### src/dpi_dp.sv
// Datapath: pose registers, shift-add multiplier, restoring divider, CORDIC
`include "diff_drive_pose_integrator_unit_macros.svh"

module dpi_dp #(
    parameter int MAX_STEPS = dpi_pkg::MAX_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dpi_pkg::t_dp_cmd   i_dp_cmd,
    output dpi_pkg::t_dp_sts   o_dp_sts,
    input  logic [15:0]        i_radius,
    input  logic [19:0]        i_sep,
    input  logic [19:0]        i_step,
    input  logic               i_cmd,
    input  logic signed [31:0] i_load_x,
    input  logic signed [31:0] i_load_y,
    input  logic [31:0]        i_load_heading,
    input  logic [23:0]        i_elapsed_time,
    input  logic signed [23:0] i_left_wheel_speed,
    input  logic signed [23:0] i_right_wheel_speed,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic [31:0]        o_pose_heading,
    output logic [6:0]         o_substeps_done,
    output logic               o_steps_clipped
);

    localparam int NW = $clog2(MAX_STEPS + 1);

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -37'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // pose and step control
    logic signed [31:0] r_x, r_y;
    logic [31:0]        r_h;
    logic [NW-1:0]      r_n, r_k;
    logic               r_clip;

    // captured item
    logic [23:0] r_dt;
    logic [24:0] r_sm, r_tm;
    logic        r_sneg, r_tneg;
    logic [39:0] r_dmag;

    // multiplier
    logic        r_mbusy;
    logic [4:0]  r_mcnt;
    logic [63:0] r_ma;
    logic [31:0] r_mb;
    logic [95:0] r_acc;

    // divider
    logic        r_dbusy;
    logic [6:0]  r_dcnt;
    logic [95:0] r_num;
    logic [51:0] r_rem;
    logic [47:0] r_quo;
    logic [50:0] r_dvs;

    // CORDIC
    logic               r_tbusy;
    logic [4:0]         r_ci;
    logic               r_flip;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic signed [27:0] r_c, r_s;

    logic        w_is_mul, w_is_div, w_mstart, w_dstart, w_tstart;
    logic [63:0] w_ma;
    logic [31:0] w_mb;
    logic [95:0] w_num;
    logic [19:0] w_sep, w_st;

    logic signed [24:0] w_sum, w_dif;
    logic [51:0]        w_rt;
    logic               w_ge;

    logic signed [33:0] w_xs, w_ys, w_at, w_nx, w_ny, w_nz, w_fx, w_fy;
    logic [31:0]        w_hf, w_a;
    logic               w_flip;

    logic [31:0]        w_dh;
    logic               w_neg;
    logic signed [31:0] w_pos;
    logic [67:0]        w_pmag;
    logic signed [67:0] w_p, w_pr;
    logic signed [35:0] w_inc;
    logic signed [36:0] w_psum;
    logic signed [31:0] w_newpos;
    logic               w_big;

    assign w_sep = (i_sep == 20'd0) ? 20'd1 : i_sep;
    assign w_st  = (i_step == 20'd0) ? 20'd1 : i_step;

    assign w_sum = 25'(i_left_wheel_speed) + 25'(i_right_wheel_speed);
    assign w_dif = 25'(i_right_wheel_speed) - 25'(i_left_wheel_speed);

    always_comb begin
        w_is_mul = 1'b0;
        w_is_div = 1'b0;
        w_ma     = r_acc[63:0];
        w_mb     = 32'd0;
        w_num    = r_acc;
        case (i_dp_cmd.op)
            dpi_pkg::OP_DEND: begin
                w_is_mul = 1'b1;
                w_ma     = 64'(r_n);
                w_mb     = dpi_pkg::TWO_MEG;
            end
            dpi_pkg::OP_RSM: begin
                w_is_mul = 1'b1;
                w_ma     = 64'(i_radius);
                w_mb     = 32'(r_sm);
            end
            dpi_pkg::OP_RSMDT, dpi_pkg::OP_RTMDT: begin
                w_is_mul = 1'b1;
                w_mb     = 32'(r_dt);
            end
            dpi_pkg::OP_SEPN: begin
                w_is_mul = 1'b1;
                w_ma     = 64'(w_sep);
                w_mb     = 32'(r_n);
            end
            dpi_pkg::OP_M1E6: begin
                w_is_mul = 1'b1;
                w_mb     = dpi_pkg::ONE_MEG;
            end
            dpi_pkg::OP_RTM: begin
                w_is_mul = 1'b1;
                w_ma     = 64'(i_radius);
                w_mb     = 32'(r_tm);
            end
            dpi_pkg::OP_TURN: begin
                w_is_mul = 1'b1;
                w_mb     = dpi_pkg::TURN_PER_RAD;
            end
            dpi_pkg::OP_MULX: begin
                w_is_mul = 1'b1;
                w_ma     = 64'(r_dmag);
                w_mb     = 32'(r_c[27] ? -r_c : r_c);
            end
            dpi_pkg::OP_MULY: begin
                w_is_mul = 1'b1;
                w_ma     = 64'(r_dmag);
                w_mb     = 32'(r_s[27] ? -r_s : r_s);
            end
            dpi_pkg::OP_DIVN: begin
                w_is_div = 1'b1;
                w_num    = 96'(r_dt);
            end
            dpi_pkg::OP_DIVD, dpi_pkg::OP_DIVH: w_is_div = 1'b1;
            default: ;
        endcase
    end

    assign w_mstart = i_dp_cmd.go && w_is_mul && !r_mbusy;
    assign w_dstart = i_dp_cmd.go && w_is_div && !r_dbusy;
    assign w_tstart = i_dp_cmd.go && (i_dp_cmd.op == dpi_pkg::OP_TRIG) && !r_tbusy;

    assign w_rt = {r_rem[50:0], r_num[95]};
    assign w_ge = (w_rt >= {1'b0, r_dvs});

    assign w_hf   = r_h + 32'h4000_0000;
    assign w_flip = w_hf[31];
    assign w_a    = w_flip ? (r_h + 32'h8000_0000) : r_h;
    assign w_xs   = r_cx >>> r_ci;
    assign w_ys   = r_cy >>> r_ci;
    assign w_at   = $signed({2'b00, dpi_pkg::atan_turn(r_ci)});
    assign w_nx   = r_cz[33] ? (r_cx + w_ys) : (r_cx - w_ys);
    assign w_ny   = r_cz[33] ? (r_cy - w_xs) : (r_cy + w_xs);
    assign w_nz   = r_cz[33] ? (r_cz + w_at) : (r_cz - w_at);
    assign w_fx   = r_flip ? -w_nx : w_nx;
    assign w_fy   = r_flip ? -w_ny : w_ny;

    assign w_dh = r_tneg ? (32'd0 - r_quo[47:16]) : r_quo[47:16];

    assign w_neg    = ((i_dp_cmd.op == dpi_pkg::OP_UPDY) ? r_s[27] : r_c[27]) ^ r_sneg;
    assign w_pos    = (i_dp_cmd.op == dpi_pkg::OP_UPDY) ? r_y : r_x;
    assign w_pmag   = {1'b0, r_acc[66:0]};
    assign w_p      = w_neg ? -$signed(w_pmag) : $signed(w_pmag);
    assign w_pr     = w_p + 68'sd2147483648;
    assign w_inc    = $signed(w_pr[67:32]);
    assign w_psum   = 37'(w_inc) + 37'(w_pos);
    assign w_newpos = sat32(w_psum);

    assign w_big = (r_quo > 48'(MAX_STEPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_h     <= '0;
            r_n     <= '0;
            r_k     <= '0;
            r_clip  <= 1'b0;
            r_mbusy <= 1'b0;
            r_mcnt  <= '0;
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
            r_tbusy <= 1'b0;
            r_ci    <= '0;
        end else begin
            if (i_dp_cmd.go) begin
                case (i_dp_cmd.op)
                    dpi_pkg::OP_CAPTURE: begin
                        r_n    <= '0;
                        r_k    <= '0;
                        r_clip <= 1'b0;
                        if (i_cmd == dpi_pkg::CMD_LOAD) begin
                            r_x <= i_load_x;
                            r_y <= i_load_y;
                            r_h <= i_load_heading;
                        end
                    end
                    dpi_pkg::OP_CLIP: begin
                        r_n    <= w_big ? NW'(MAX_STEPS) : r_quo[NW-1:0];
                        r_clip <= w_big;
                        r_k    <= '0;
                    end
                    dpi_pkg::OP_UPDX: r_x <= w_newpos;
                    dpi_pkg::OP_UPDY: begin
                        r_y <= w_newpos;
                        r_h <= r_h + w_dh;
                        r_k <= r_k + 1'b1;
                    end
                    default: ;
                endcase
            end

            if (w_mstart) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 1'b1;
                if (r_mcnt == dpi_pkg::MUL_LAST) r_mbusy <= 1'b0;
            end

            if (w_dstart) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == dpi_pkg::DIV_LAST) r_dbusy <= 1'b0;
            end

            if (w_tstart) begin
                r_tbusy <= 1'b1;
                r_ci    <= '0;
            end else if (r_tbusy) begin
                r_ci <= r_ci + 1'b1;
                if (r_ci == dpi_pkg::TRIG_LAST) r_tbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.go && (i_dp_cmd.op == dpi_pkg::OP_CAPTURE)) begin
            r_dt   <= i_elapsed_time;
            r_sm   <= w_sum[24] ? 25'(-w_sum) : 25'(w_sum);
            r_sneg <= w_sum[24];
            r_tm   <= w_dif[24] ? 25'(-w_dif) : 25'(w_dif);
            r_tneg <= w_dif[24];
        end

        if (w_mstart) begin
            r_ma  <= w_ma;
            r_mb  <= w_mb;
            r_acc <= '0;
            case (i_dp_cmd.op)
                dpi_pkg::OP_RSM, dpi_pkg::OP_RTM: r_dvs <= r_acc[50:0];
                dpi_pkg::OP_SEPN:                 r_dmag <= r_quo[47:8];
                default: ;
            endcase
        end else if (r_mbusy) begin
            r_acc <= {r_acc[94:0], 1'b0} + (r_mb[31] ? {32'd0, r_ma} : 96'd0);
            r_mb  <= {r_mb[30:0], 1'b0};
        end

        if (w_dstart) begin
            r_num <= w_num;
            r_rem <= '0;
            r_quo <= '0;
            if (i_dp_cmd.op == dpi_pkg::OP_DIVN) r_dvs <= 51'(w_st);
        end else if (r_dbusy) begin
            r_num <= {r_num[94:0], 1'b0};
            r_rem <= w_ge ? (w_rt - {1'b0, r_dvs}) : w_rt;
            r_quo <= {r_quo[46:0], w_ge};
        end

        if (w_tstart) begin
            r_cx   <= dpi_pkg::CORDIC_GAIN;
            r_cy   <= '0;
            r_cz   <= 34'($signed(w_a));
            r_flip <= w_flip;
        end else if (r_tbusy) begin
            r_cx <= w_nx;
            r_cy <= w_ny;
            r_cz <= w_nz;
            if (r_ci == dpi_pkg::TRIG_LAST) begin
                r_c <= w_fx[33:6];
                r_s <= w_fy[33:6];
            end
        end
    end

    always_comb begin
        o_dp_sts.quo_zero  = (r_quo == 48'd0);
        o_dp_sts.last_step = (r_k == (r_n - 1'b1));
        case (i_dp_cmd.op)
            dpi_pkg::OP_CAPTURE, dpi_pkg::OP_CLIP,
            dpi_pkg::OP_UPDX, dpi_pkg::OP_UPDY:
                o_dp_sts.done = i_dp_cmd.go;
            dpi_pkg::OP_DIVN, dpi_pkg::OP_DIVD, dpi_pkg::OP_DIVH:
                o_dp_sts.done = r_dbusy && (r_dcnt == dpi_pkg::DIV_LAST);
            dpi_pkg::OP_TRIG:
                o_dp_sts.done = r_tbusy && (r_ci == dpi_pkg::TRIG_LAST);
            dpi_pkg::OP_DEND, dpi_pkg::OP_RSM, dpi_pkg::OP_RSMDT, dpi_pkg::OP_SEPN,
            dpi_pkg::OP_M1E6, dpi_pkg::OP_RTM, dpi_pkg::OP_RTMDT, dpi_pkg::OP_TURN,
            dpi_pkg::OP_MULX, dpi_pkg::OP_MULY:
                o_dp_sts.done = r_mbusy && (r_mcnt == dpi_pkg::MUL_LAST);
            default:
                o_dp_sts.done = 1'b0;
        endcase
    end

    assign o_pose_x        = r_x;
    assign o_pose_y        = r_y;
    assign o_pose_heading  = r_h;
    assign o_substeps_done = 7'(r_n);
    assign o_steps_clipped = r_clip;

    `DPI_ASSERT(a_units_excl, i_clk, i_rst_n, r_mbusy, !r_dbusy && !r_tbusy)
    `DPI_ASSERT(a_step_bound, i_clk, i_rst_n, 1'b1, (r_n <= NW'(MAX_STEPS)) && (r_k <= r_n))
    `DPI_ASSERT_NEXT(a_head_hold, i_clk, i_rst_n, r_mbusy || r_dbusy || r_tbusy, $stable(r_h))

endmodule

### src/diff_drive_pose_integrator_unit.sv
// Top level of the differential-drive pose integrator
//
//  channel  | direction | handshake                  | beat
//  ---------+-----------+----------------------------+------------------------------
//  input    | in        | i_in_valid / o_in_stall    | cmd, load pose, dt, speeds
//  output   | out       | o_out_valid / i_out_stall  | pose, substeps, clipped flag
//  config   | in        | APB psel/penable/pwrite    | radius, separation, step time
//
//  A load beat goes straight to publication; an advance beat's time is set by the shared
//  shift-add multiplier and restoring divider, one bit a cycle, and by the 30-iteration
//  CORDIC run once per substep.
//  Synchronous active-low reset clears the pose and restores the register defaults.
//  One beat is worked at a time; a new one is taken while the last result waits.
module diff_drive_pose_integrator_unit #(
    parameter int MAX_STEPS = dpi_pkg::MAX_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dpi_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic signed [31:0]         i_load_x,
    input  logic signed [31:0]         i_load_y,
    input  logic [31:0]                i_load_heading,
    input  logic [23:0]                i_elapsed_time,
    input  logic signed [23:0]         i_left_wheel_speed,
    input  logic signed [23:0]         i_right_wheel_speed,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [31:0]         o_pose_x,
    output logic signed [31:0]         o_pose_y,
    output logic [31:0]                o_pose_heading,
    output logic [6:0]                 o_substeps_done,
    output logic                       o_steps_clipped
);

    logic [15:0] r_radius;
    logic [19:0] r_sep, r_step;
    logic        r_out_valid;

    logic signed [31:0] r_pose_x, r_pose_y;
    logic [31:0]        r_pose_heading;
    logic [6:0]         r_substeps_done;
    logic               r_steps_clipped;

    logic               w_out_free, w_publish, w_wr;
    dpi_pkg::t_dp_cmd   w_dp_cmd;
    dpi_pkg::t_dp_sts   w_dp_sts;
    logic signed [31:0] w_x, w_y;
    logic [31:0]        w_h;
    logic [6:0]         w_n;
    logic               w_clip;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= dpi_pkg::RADIUS_RST;
            r_sep    <= dpi_pkg::SEP_RST;
            r_step   <= dpi_pkg::STEP_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                dpi_pkg::REG_RADIUS: r_radius <= pwdata[15:0];
                dpi_pkg::REG_SEP:    r_sep    <= pwdata[19:0];
                dpi_pkg::REG_STEP:   r_step   <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dpi_pkg::REG_RADIUS: prdata = 32'(r_radius);
            dpi_pkg::REG_SEP:    prdata = 32'(r_sep);
            dpi_pkg::REG_STEP:   prdata = 32'(r_step);
            default:             prdata = 32'd0;
        endcase
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    dpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_out_free (w_out_free),
        .i_dp_sts   (w_dp_sts),
        .o_in_stall (o_in_stall),
        .o_publish  (w_publish),
        .o_dp_cmd   (w_dp_cmd)
    );

    dpi_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_dp_cmd            (w_dp_cmd),
        .o_dp_sts            (w_dp_sts),
        .i_radius            (r_radius),
        .i_sep               (r_sep),
        .i_step              (r_step),
        .i_cmd               (i_cmd),
        .i_load_x            (i_load_x),
        .i_load_y            (i_load_y),
        .i_load_heading      (i_load_heading),
        .i_elapsed_time      (i_elapsed_time),
        .i_left_wheel_speed  (i_left_wheel_speed),
        .i_right_wheel_speed (i_right_wheel_speed),
        .o_pose_x            (w_x),
        .o_pose_y            (w_y),
        .o_pose_heading      (w_h),
        .o_substeps_done     (w_n),
        .o_steps_clipped     (w_clip)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_publish) begin
            r_pose_x        <= w_x;
            r_pose_y        <= w_y;
            r_pose_heading  <= w_h;
            r_substeps_done <= w_n;
            r_steps_clipped <= w_clip;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pose_x        = r_pose_x;
    assign o_pose_y        = r_pose_y;
    assign o_pose_heading  = r_pose_heading;
    assign o_substeps_done = r_substeps_done;
    assign o_steps_clipped = r_steps_clipped;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the differential-drive pose integrator
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT = 4000000;

    typedef struct {
        logic               cmd;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic [31:0]        lh;
        logic [23:0]        dt;
        logic signed [23:0] ul;
        logic signed [23:0] ur;
    } t_beat;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        h;
        logic [6:0]         steps;
        logic               clipped;
    } t_pose;

    class t_pose_scoreboard;
        t_pose              pending[$];
        int                 errors;
        int                 checked;
        logic [15:0]        radius;
        logic [19:0]        sep;
        logic [19:0]        step_us;
        longint signed      px;
        longint signed      py;
        logic [31:0]        hd;
        logic [31:0]        atan_tab[30];

        function new();
            atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                         81, 41, 20, 10, 5, 3, 1};
            radius = dpi_pkg::RADIUS_RST;
            sep = dpi_pkg::SEP_RST;
            step_us = dpi_pkg::STEP_RST;
            px = 0;
            py = 0;
            hd = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                dpi_pkg::REG_RADIUS: radius = v[15:0];
                dpi_pkg::REG_SEP:    sep = v[19:0];
                dpi_pkg::REG_STEP:   step_us = v[19:0];
                default: ;
            endcase
        endfunction

        function void sincos(logic [31:0] a, output longint signed c, output longint signed s);
            logic          flip;
            longint signed z, x, y, xs, ys;
            flip = ((a + 32'h40000000) & 32'h80000000) != 0;
            if (flip) a = a + 32'h80000000;
            z = longint'($signed(a));
            x = 652032874;
            y = 0;
            for (int i = 0; i < 30; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z = z - longint'(atan_tab[i]);
                end else begin
                    x = x + ys; y = y - xs; z = z + longint'(atan_tab[i]);
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            c = x >>> 6;
            s = y >>> 6;
        endfunction

        function longint signed sat(longint signed v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void note_input(t_beat b);
            t_pose             e;
            longint unsigned   r, sp, st, dt, n, sm, tm, dmag, den;
            longint signed     sum, dif, d, c, s;
            logic [127:0]      prod, q;
            logic [31:0]       dh;
            e.steps = 0;
            e.clipped = 0;
            if (b.cmd == dpi_pkg::CMD_LOAD) begin
                px = longint'(b.lx);
                py = longint'(b.ly);
                hd = b.lh;
            end else begin
                r = radius;
                sp = (sep == 0) ? 1 : sep;
                st = (step_us == 0) ? 1 : step_us;
                dt = b.dt;
                n = dt / st;
                if (n > dpi_pkg::MAX_STEPS_DEF) begin
                    n = dpi_pkg::MAX_STEPS_DEF;
                    e.clipped = 1;
                end
                if (n > 0) begin
                    sum = longint'(b.ul) + longint'(b.ur);
                    dif = longint'(b.ur) - longint'(b.ul);
                    sm = (sum < 0) ? -sum : sum;
                    tm = (dif < 0) ? -dif : dif;
                    dmag = (r * sm * dt) / (64'd2000000 * n) / 256;
                    d = (sum < 0) ? -longint'(dmag) : longint'(dmag);
                    prod = 128'(r * tm * dt) * 128'(64'd683565276);
                    den = sp * n * 64'd1000000;
                    q = prod / 128'(den);
                    dh = q[47:16];
                    if (dif < 0) dh = 32'd0 - dh;
                    for (longint unsigned i = 0; i < n; i++) begin
                        sincos(hd, c, s);
                        px = sat(px + ((c * d + 64'sd2147483648) >>> 32));
                        py = sat(py + ((s * d + 64'sd2147483648) >>> 32));
                        hd = hd + dh;
                    end
                    e.steps = n[6:0];
                end
            end
            e.x = px[31:0];
            e.y = py[31:0];
            e.h = hd;
            pending.push_back(e);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch on %s: got %0h want %0h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(t_pose g);
            t_pose e;
            if (pending.size() == 0) begin
                report("unexpected beat", 1, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (g.x !== e.x) report("pose_x", g.x, e.x);
            if (g.y !== e.y) report("pose_y", g.y, e.y);
            if (g.h !== e.h) report("pose_heading", g.h, e.h);
            if (g.steps !== e.steps) report("substeps_done", g.steps, e.steps);
            if (g.clipped !== e.clipped) report("steps_clipped", g.clipped, e.clipped);
        endtask
    endclass

    logic                       i_clk = 0;
    logic                       i_rst_n = 0;
    logic                       psel = 0, penable = 0, pwrite = 0;
    logic [dpi_pkg::APB_AW-1:0] paddr = 0;
    logic [31:0]                pwdata = 0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       i_in_valid = 0;
    logic                       o_in_stall;
    logic                       i_cmd = 0;
    logic signed [31:0]         i_load_x = 0, i_load_y = 0;
    logic [31:0]                i_load_heading = 0;
    logic [23:0]                i_elapsed_time = 0;
    logic signed [23:0]         i_left_wheel_speed = 0, i_right_wheel_speed = 0;
    logic                       o_out_valid;
    logic                       i_out_stall = 0;
    logic signed [31:0]         o_pose_x, o_pose_y;
    logic [31:0]                o_pose_heading;
    logic [6:0]                 o_substeps_done;
    logic                       o_steps_clipped;

    t_pose_scoreboard sb = new();
    int  hold_cycles = 0;
    bit  calm = 0;
    int  cycles = 0;
    int  sent = 0;
    int  clip_seen = 0;

    diff_drive_pose_integrator_unit DUT (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 17);
        end
    end

    always @(posedge i_clk) begin
        t_pose g;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            g.x = o_pose_x;
            g.y = o_pose_y;
            g.h = o_pose_heading;
            g.steps = o_substeps_done;
            g.clipped = o_steps_clipped;
            if (o_steps_clipped) clip_seen++;
            sb.check_result(g);
        end
    end

    task apb_write(logic [1:0] idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= dpi_pkg::APB_AW'({idx, 2'b00}); pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, v);
    endtask

    // called at a falling edge; the input goes idle until every result is back
    task drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task set_regs(logic [31:0] r, logic [31:0] s, logic [31:0] st);
        drain();
        apb_write(dpi_pkg::REG_RADIUS, r);
        apb_write(dpi_pkg::REG_SEP, s);
        apb_write(dpi_pkg::REG_STEP, st);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task send(t_beat b);
        int gap;
        gap = calm ? 0 : (($urandom_range(99) < 17) ? $urandom_range(1, 6) : 0);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_cmd <= b.cmd;
        i_load_x <= b.lx;
        i_load_y <= b.ly;
        i_load_heading <= b.lh;
        i_elapsed_time <= b.dt;
        i_left_wheel_speed <= b.ul;
        i_right_wheel_speed <= b.ur;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(b);
        sent++;
        @(negedge i_clk);
    endtask

    task send_load(logic [31:0] x, logic [31:0] y, logic [31:0] h);
        t_beat b;
        b = '{dpi_pkg::CMD_LOAD, x, y, h, 24'($urandom), 24'($urandom), 24'($urandom)};
        send(b);
    endtask

    task send_adv(logic [23:0] dt, logic [23:0] ul, logic [23:0] ur);
        t_beat b;
        b = '{dpi_pkg::CMD_ADVANCE, $urandom, $urandom, $urandom, dt, ul, ur};
        send(b);
    endtask

    // elapsed time mostly giving a few substeps, now and then at or past the clip
    function logic [23:0] pick_dt();
        longint unsigned st, n, v;
        st = (sb.step_us == 0) ? 1 : sb.step_us;
        n = ($urandom_range(99) < 8) ? $urandom_range(64, 90) : $urandom_range(0, 5);
        v = st * n + $urandom_range(0, 32'(st - 1));
        if (v > 24'hFFFFFF) v = 24'hFFFFFF - $urandom_range(0, 32'(st - 1));
        return v[23:0];
    endfunction

    task random_items(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 25) send_load($urandom, $urandom, $urandom);
            else if ($urandom_range(99) < 10)
                send_adv(24'($urandom), 24'($urandom), 24'($urandom));
            else send_adv(pick_dt(), 24'($urandom), 24'($urandom));
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed, reset settings
        send_load(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_adv(24'd0, 24'h7FFFFF, 24'h800000);
        send_adv(24'd999, 24'h7FFFFF, 24'h7FFFFF);
        send_load(32'h7FFF_0000, 32'h8001_0000, 32'h0);
        send_adv(24'd5000, 24'h7FFFFF, 24'h7FFFFF);
        send_adv(24'd3000, 24'h800000, 24'h800000);
        send_adv(24'd2000, 24'h800000, 24'h7FFFFF);
        send_adv(24'd2000, 24'h7FFFFF, 24'h800000);
        send_adv(24'd1000, 24'd0, 24'd0);
        send_adv(24'd4000, 24'h012345, 24'h012345);
        send_adv(24'hFFFFFF, 24'h7FFFFF, 24'h800001);
        send_load(32'h0, 32'h0, 32'h4000_0000);
        send_adv(24'd1500, 24'h010000, 24'h020000);
        send_adv(24'd1500, 24'hFFF000, 24'hFFE000);

        // extremes: largest radius, zero separation, zero step time
        set_regs(32'hFFFF, 32'h0, 32'h0);
        send_adv(24'd1, 24'h7FFFFF, 24'h800000);
        send_adv(24'd63, 24'h400000, 24'hC00000);
        send_adv(24'd64, 24'h7FFFFF, 24'h000001);
        send_adv(24'd200, 24'h000001, 24'h7FFFFF);
        random_items(10);

        // smallest radius and separation 1, largest separation and step time
        set_regs(32'h1, 32'h1, 32'd1000000);
        send_adv(24'd999999, 24'h7FFFFF, 24'h800000);
        send_adv(24'hFFFFFF, 24'h7FFFFF, 24'h800000);
        set_regs(32'h0, 32'hFFFFF, 32'hFFFFF);
        send_adv(24'hFFFFFF, 24'h7FFFFF, 24'h000000);
        set_regs(32'hFFFF, 32'h1, 32'h1);
        send_adv(24'd40, 24'h7FFFFF, 24'h800000);

        // pressure: long receiver hold-off while loads keep coming
        drain();
        hold_cycles = 400;
        for (int k = 0; k < 6; k++) send_load($urandom, $urandom, $urandom);
        drain();

        set_regs(32'(dpi_pkg::RADIUS_RST), 32'(dpi_pkg::SEP_RST), 32'(dpi_pkg::STEP_RST));
        random_items(40);
        calm = 1;
        random_items(20);
        calm = 0;

        set_regs($urandom_range(1, 65535), $urandom_range(1, 1048575),
                 $urandom_range(1, 20000));
        random_items(30);
        set_regs($urandom_range(1, 65535), $urandom_range(1, 1048575),
                 $urandom_range(1, 300));
        random_items(20);

        drain();
        repeat (200) @(negedge i_clk);
        $display("%0d beats sent, %0d results checked, %0d with the step count clipped",
                 sent, sb.checked, clip_seen);
        $display("loads, advances across register extremes, zero time and back-pressure");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
